// File: sv/hll_register_max_update_top_assert.svh
// Assertion macros for the HLL register update block.
// They are empty when SYNTHESIS is defined.
`ifndef HLL_REGISTER_MAX_UPDATE_TOP_ASSERT_SVH
`define HLL_REGISTER_MAX_UPDATE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// cond must hold at every clock edge outside reset
`define HRMU_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("hrmu: invariant violated");

// cons must hold in the cycle after ante
`define HRMU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hrmu: sequence check failed");

`else

`define HRMU_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define HRMU_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: sv/hrmu_pkg.sv
package hrmu_pkg;

  // six-bit register values
  localparam int VAL_W = 6;
  // coupon layout: candidate value in the top bits
  localparam int COUPON_W  = 32;
  localparam int VAL_SHIFT = 26;
  // lg_k register
  localparam int LG_K_W     = 4;
  localparam int LG_K_MIN   = 4;
  localparam int LG_K_RESET = 12;

  // outcome of one register update
  typedef struct packed {
    logic changed;
    logic was_zero;
    logic error;
  } upd_flags_t;

endpackage

// File: sv/hrmu_ram.sv
module hrmu_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port; old data when read and write hit the same entry
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/hrmu_update.sv
module hrmu_update
  import hrmu_pkg::*;
(
  input  logic [VAL_W-1:0] cand,
  input  logic [VAL_W-1:0] cur,
  output logic [VAL_W-1:0] new_value,
  output upd_flags_t       flags
);

  // max update; a zero candidate is an error and leaves the slot alone
  always_comb begin
    flags.error    = (cand == '0);
    flags.changed  = !flags.error && (cand > cur);
    flags.was_zero = flags.changed && (cur == '0);
    new_value      = flags.changed ? cand : cur;
  end

endmodule

// File: sv/hll_register_max_update_top.sv
// HyperLogLog register update with six-bit registers.
// Input stream (s_tvalid/s_tready/s_tdata): one 32-bit coupon per beat; bits
// [MAX_LG_K-1:0] masked to lg_k bits pick the slot, bits [31:26] are the candidate.
// Output stream (m_tvalid/m_tready/m_tdata/m_tuser): one beat per coupon with the
// slot, old and new value, changed and was_zero flags and the count of slots
// still zero; m_tuser flags a zero candidate, which changes nothing.
// Configuration: cfg_we writes lg_k (clamped to 4..MAX_LG_K) from cfg_wdata and
// empties the sketch.
// Throughput is one coupon per cycle while m_tready stays high and no clearing pass
// runs: the slot store is a dual-port RAM with one read-modify-write per beat, and
// a write from the beat just ahead is forwarded. A coupon passes two registers on
// its way to the output: the RAM read/input stage and the output register.
// Reset and every lg_k write start a clearing pass over all 2^MAX_LG_K slots,
// one slot a cycle; s_tready is low during it.
// When m_tready is low the output register holds its beat, the input stage holds
// its beat once it has one and s_tready then drops; nothing is lost or repeated.
`include "hll_register_max_update_top_assert.svh"

module hll_register_max_update_top
  import hrmu_pkg::*;
#(
  parameter  int MAX_LG_K = 12,
  localparam int SLOT_W   = MAX_LG_K,
  localparam int CNT_W    = MAX_LG_K + 1,
  localparam int M_USED_W = SLOT_W + 2 * VAL_W + 2 + CNT_W,
  localparam int M_W      = ((M_USED_W + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [COUPON_W-1:0] s_tdata,   // coupon
  output logic                m_tvalid,
  input  logic                m_tready,
  // slot_index, old_value, new_value, changed, was_zero, zero_count, zero pad
  output logic [M_W-1:0]      m_tdata,
  output logic [0:0]          m_tuser,   // error
  input  logic                cfg_we,
  input  logic [LG_K_W-1:0]   cfg_wdata  // lg_k
);

  localparam int LGW       = $clog2(MAX_LG_K + 1);
  localparam int LG_RST    = (LG_K_RESET > MAX_LG_K) ? MAX_LG_K : LG_K_RESET;
  localparam int ZERO_RST  = 1 << LG_RST;

  function automatic logic [LGW-1:0] clamp_lg(input logic [LG_K_W-1:0] v);
    logic [LGW-1:0] r;
    if (int'(v) < LG_K_MIN) begin
      r = LGW'(LG_K_MIN);
    end else if (int'(v) > MAX_LG_K) begin
      r = LGW'(MAX_LG_K);
    end else begin
      r = LGW'(v);
    end
    return r;
  endfunction

  logic [LG_K_W-1:0] lg_k;
  logic [LGW-1:0]    eff_lg;
  logic [SLOT_W-1:0] slot_mask;
  logic [SLOT_W-1:0] in_slot;
  logic              accept;

  logic              clearing;
  logic [SLOT_W-1:0] clr_addr;

  logic              st1_valid;
  logic              st1_adv;
  logic [SLOT_W-1:0] st1_slot;
  logic [VAL_W-1:0]  st1_cand;
  logic              fwd_hit;
  logic [VAL_W-1:0]  fwd_val;

  logic [VAL_W-1:0]  rd_data;
  logic [VAL_W-1:0]  cur;
  logic [VAL_W-1:0]  upd_new;
  upd_flags_t        flags;
  logic              upd_we;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;

  logic [CNT_W-1:0]  zeros_left;
  logic [CNT_W-1:0]  zeros_left_next;

  // lg_k register
  always_ff @(posedge clk) begin
    if (rst) begin
      lg_k <= LG_K_W'(LG_K_RESET);
    end else if (cfg_we) begin
      lg_k <= cfg_wdata;
    end
  end

  assign eff_lg    = clamp_lg(lg_k);
  assign slot_mask = SLOT_W'((CNT_W'(1) << eff_lg) - CNT_W'(1));
  assign in_slot   = s_tdata[SLOT_W-1:0] & slot_mask;

  // clearing pass over the whole store after reset and each lg_k write
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + SLOT_W'(1);
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  // handshake
  assign st1_adv  = !m_tvalid || m_tready;
  assign s_tready = !clearing && (!st1_valid || st1_adv);
  assign accept   = s_tvalid && s_tready;

  // input stage: RAM read is issued on the accepting edge
  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
    end else if (accept) begin
      st1_valid <= 1'b1;
    end else if (st1_adv) begin
      st1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st1_slot <= in_slot;
      st1_cand <= s_tdata[COUPON_W-1 -: VAL_W];
      // the beat ahead writes on this same edge; the RAM read misses it
      fwd_hit  <= upd_we && (st1_slot == in_slot);
      fwd_val  <= upd_new;
    end
  end

  hrmu_ram #(
    .ADDR_W (SLOT_W),
    .DATA_W (VAL_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_slot),
    .rdata (rd_data)
  );

  assign cur = fwd_hit ? fwd_val : rd_data;

  hrmu_update u_update (
    .cand      (st1_cand),
    .cur       (cur),
    .new_value (upd_new),
    .flags     (flags)
  );

  assign upd_we = st1_valid && st1_adv && flags.changed;

  // RAM write: clearing pass has the port, else the update
  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = upd_we;
      ram_waddr = st1_slot;
      ram_wdata = upd_new;
    end
  end

  // zero-slot count, saturating at zero
  always_comb begin
    zeros_left_next = zeros_left;
    if (st1_valid && flags.was_zero && zeros_left != '0) begin
      zeros_left_next = zeros_left - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zeros_left <= CNT_W'(ZERO_RST);
    end else if (cfg_we) begin
      zeros_left <= CNT_W'(1) << clamp_lg(cfg_wdata);
    end else if (st1_valid && st1_adv) begin
      zeros_left <= zeros_left_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (st1_valid && st1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st1_valid && st1_adv) begin
      m_tdata <= M_W'({zeros_left_next, flags.was_zero, flags.changed,
                       upd_new, cur, st1_slot});
      m_tuser <= flags.error;
    end
  end

  // checks
  `HRMU_ASSERT_ALWAYS(a_zero_count_bound, clk, rst,
    zeros_left <= (CNT_W'(1) << eff_lg))
  `HRMU_ASSERT_NEXT(a_accept_loads_stage, clk, rst, accept, st1_valid)
  `HRMU_ASSERT_ALWAYS(a_new_not_below_old, clk, rst,
    !m_tvalid || (m_tdata[SLOT_W+2*VAL_W-1 -: VAL_W] >= m_tdata[SLOT_W+VAL_W-1 -: VAL_W]))
  `HRMU_ASSERT_ALWAYS(a_no_accept_while_clearing, clk, rst, !(clearing && accept))

endmodule

// File: sim/hll_register_max_update_top_tb.sv
`timescale 1ns / 1ps

module hll_register_max_update_top_tb;
  import hrmu_pkg::*;

  localparam int MAX_LG      = 12;
  localparam int SLOTS       = 1 << MAX_LG;
  localparam int CNT_W       = MAX_LG + 1;
  localparam int TDATA_W     = ((MAX_LG + 2 * VAL_W + 2 + CNT_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_BEATS  = 180;
  localparam int N_SETTINGS  = 8;

  // lg_k values written in turn; the out-of-range ones exercise clamping
  localparam logic [LG_K_W-1:0] LG_SEQ [N_SETTINGS] = '{
    4'd4, 4'd0, 4'd15, 4'd9, 4'd3, 4'd13, 4'd12, 4'd5
  };

  // corner coupons at the reset lg_k of 12
  localparam logic [COUPON_W-1:0] CORNER [12] = '{
    {6'd0,  26'h0000000},   // zero candidate on an empty slot
    {6'd63, 26'h0000000},   // largest value into an empty slot
    {6'd1,  26'h0000000},   // smaller, no change
    {6'd63, 26'h0000000},   // equal, no change
    {6'd0,  26'h0000000},   // zero candidate on a filled slot
    {6'd1,  26'h0000FFF},   // top slot
    {6'd2,  26'h3FFFFFF},   // key bits above lg_k dropped
    {6'd5,  26'h3FFF001},
    32'hFFFF_FFFF,
    {6'd3,  26'h00002A5},   // one after another on one slot
    {6'd4,  26'h00002A5},
    {6'd2,  26'h00002A5}
  };

  typedef struct packed {
    logic [MAX_LG-1:0] slot;
    logic [VAL_W-1:0]  old_val;
    logic [VAL_W-1:0]  new_val;
    logic              changed;
    logic              was_zero;
    logic [CNT_W-1:0]  zero_cnt;
    logic              err;
  } reg_update_t;

  // Sketch predictor and store of outstanding register updates
  class hll_update_scoreboard;
    logic [VAL_W-1:0] regs [SLOTS];
    int unsigned      zeros_left;
    int unsigned      lg_eff;
    int unsigned      errors;
    int unsigned      coupons;
    int unsigned      beats;
    reg_update_t      update_q[$];

    function new();
      errors  = 0;
      coupons = 0;
      beats   = 0;
      set_lg(LG_K_RESET);
    endfunction

    // lg_k write: clamp and start an empty sketch
    function void set_lg(int unsigned v);
      lg_eff = v;
      if (lg_eff < LG_K_MIN) lg_eff = LG_K_MIN;
      if (lg_eff > MAX_LG) lg_eff = MAX_LG;
      foreach (regs[i]) regs[i] = '0;
      zeros_left = 1 << lg_eff;
    endfunction

    function int unsigned pending();
      return update_q.size();
    endfunction

    function void note_coupon(logic [COUPON_W-1:0] c);
      reg_update_t      u;
      logic [VAL_W-1:0] cand;
      int unsigned      slot;
      slot = c[MAX_LG-1:0] & ((1 << lg_eff) - 1);
      cand = c[VAL_SHIFT +: VAL_W];
      u.slot     = MAX_LG'(slot);
      u.old_val  = regs[slot];
      u.new_val  = regs[slot];
      u.changed  = 1'b0;
      u.was_zero = 1'b0;
      u.err      = 1'b0;
      if (cand == 0) begin
        u.err = 1'b1;
      end else if (cand > regs[slot]) begin
        u.new_val  = cand;
        u.changed  = 1'b1;
        if (regs[slot] == 0) begin
          u.was_zero = 1'b1;
          if (zeros_left > 0) zeros_left--;
        end
        regs[slot] = cand;
      end
      u.zero_cnt = CNT_W'(zeros_left);
      update_q.push_back(u);
      coupons++;
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    task cmp(string field, int unsigned got, int unsigned want);
      if (got != want)
        report($sformatf("beat %0d %s got 0x%0h want 0x%0h", beats, field, got, want));
    endtask

    task check_result(logic [TDATA_W-1:0] d, logic e);
      reg_update_t want;
      if (update_q.size() == 0) begin
        report($sformatf("output beat 0x%0h with nothing outstanding", d));
      end else begin
        want = update_q.pop_front();
        cmp("slot_index", 32'(d[MAX_LG-1:0]), 32'(want.slot));
        cmp("old_value", 32'(d[MAX_LG +: VAL_W]), 32'(want.old_val));
        cmp("new_value", 32'(d[MAX_LG+VAL_W +: VAL_W]), 32'(want.new_val));
        cmp("changed", 32'(d[MAX_LG+2*VAL_W]), 32'(want.changed));
        cmp("was_zero", 32'(d[MAX_LG+2*VAL_W+1]), 32'(want.was_zero));
        cmp("zero_count", 32'(d[MAX_LG+2*VAL_W+2 +: CNT_W]), 32'(want.zero_cnt));
        cmp("error", 32'(e), 32'(want.err));
      end
      beats++;
    endtask
  endclass

  logic                clk;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [COUPON_W-1:0] s_tdata   = '0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [TDATA_W-1:0]  m_tdata;
  logic [0:0]          m_tuser;
  logic                cfg_we    = 1'b0;
  logic [LG_K_W-1:0]   cfg_wdata = '0;

  bit                   gaps_on = 1'b1;
  int unsigned          cycles  = 0;
  hll_update_scoreboard sb      = new();

  hll_register_max_update_top #(.MAX_LG_K(MAX_LG)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // output backpressure
  always @(posedge clk) begin
    m_tready <= !gaps_on || ($urandom_range(0, 99) >= 10);
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d updates outstanding", cycles, sb.pending());
      $display("hll_register_max_update_top: mismatch");
      $finish;
    end
  end

  // one coupon beat, with an occasional gap ahead of it
  task automatic send_coupon(input logic [COUPON_W-1:0] c);
    if (gaps_on && $urandom_range(0, 99) < 10) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_coupon(c);
  endtask

  // wait for every outstanding update, then the pipeline depth
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_lg(input logic [LG_K_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_lg(32'(v));
  endtask

  // typical HLL values are small; crowd a few slots now and then so they climb
  function automatic logic [COUPON_W-1:0] rand_coupon();
    logic [25:0]      key;
    logic [VAL_W-1:0] cand;
    int               r;
    key = 26'($urandom);
    if ($urandom_range(0, 2) == 0) key[MAX_LG-1:0] = MAX_LG'($urandom_range(0, 31));
    r = $urandom_range(0, 99);
    if (r < 8)       cand = '0;
    else if (r < 15) cand = '1;
    else if (r < 70) cand = VAL_W'($urandom_range(1, 8));
    else             cand = VAL_W'($urandom_range(1, 63));
    return {cand, key};
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (CORNER[i]) send_coupon(CORNER[i]);
    repeat (RAND_BEATS) send_coupon(rand_coupon());

    for (int p = 0; p < N_SETTINGS; p++) begin
      drain();
      write_lg(LG_SEQ[p]);
      // one long stretch without gaps on either side
      gaps_on = (p != 3);
      send_coupon({6'd1, 26'h3FFFFFF});
      send_coupon({6'd63, 26'h0000000});
      repeat (RAND_BEATS) send_coupon(rand_coupon());
    end
    drain();

    $display("covered %0d coupons and %0d output beats across %0d lg_k writes",
             sb.coupons, sb.beats, N_SETTINGS);
    $display("incl. clamped out-of-range lg_k, zero candidates and filled small sketches");
    if (sb.errors == 0) begin
      $display("hll_register_max_update_top: match");
    end else begin
      $display("hll_register_max_update_top: mismatch");
    end
    $finish;
  end

endmodule
